// ===== rtl/core/bsc_pkg.sv =====
// Shared types, constants and the step program for the barometric compensation block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bsc_pkg;

	localparam int BSC_FRAC_BITS = 30;
	localparam logic signed [63:0] FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam int STEP_W = 5;
	localparam int CFG_IDX_W = 3;

	// register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0_5   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_6_11  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_12_17 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SCALE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_SCALE = 3'd4;

	localparam logic [23:0] SCALE_RESET = 24'd524288;
	localparam logic KIND_TEMP = 1'b0;

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;

	typedef enum logic [2:0] {OP_NONE, OP_DIV, OP_MUL, OP_ADD, OP_END} op_t;

	typedef enum logic [4:0] {
		SRC_ZERO, SRC_RAW, SRC_LAST, SRC_T, SRC_P, SRC_ACC, SRC_Q, SRC_TP,
		SRC_C0H, SRC_C1, SRC_C00, SRC_C10, SRC_C01, SRC_C11, SRC_C20, SRC_C21,
		SRC_C30, SRC_C100
	} src_t;

	typedef enum logic [2:0] {DST_T, DST_P, DST_ACC, DST_Q, DST_TP} dst_t;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		dst_t dst;
	} cmd_t;

	typedef struct packed {
		logic accept;
		cmd_t cmd;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} stat_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic cmd_t mk(input op_t op, input src_t a, input src_t b, input dst_t d);
		cmd_t c;
		c.op = op;
		c.a = a;
		c.b = b;
		c.dst = d;
		mk = c;
	endfunction

	// Step program. ADD always adds the last product to operand a.
	function automatic cmd_t bsc_prog(input logic kind, input logic [STEP_W-1:0] step);
		cmd_t c;
		c = mk(OP_END, SRC_ZERO, SRC_ZERO, DST_ACC);
		if (kind == KIND_TEMP) begin
			unique case (step)
				5'd0: c = mk(OP_DIV, SRC_RAW, SRC_ZERO, DST_T);
				5'd1: c = mk(OP_MUL, SRC_C1, SRC_T, DST_ACC);
				5'd2: c = mk(OP_ADD, SRC_C0H, SRC_ZERO, DST_ACC);
				5'd3: c = mk(OP_MUL, SRC_C100, SRC_ACC, DST_ACC);
				default: c = mk(OP_END, SRC_ZERO, SRC_ZERO, DST_ACC);
			endcase
		end else begin
			unique case (step)
				5'd0:  c = mk(OP_DIV, SRC_LAST, SRC_ZERO, DST_T);
				5'd1:  c = mk(OP_DIV, SRC_RAW, SRC_ZERO, DST_P);
				5'd2:  c = mk(OP_MUL, SRC_P, SRC_C30, DST_ACC);
				5'd3:  c = mk(OP_ADD, SRC_C20, SRC_ZERO, DST_ACC);
				5'd4:  c = mk(OP_MUL, SRC_P, SRC_ACC, DST_ACC);
				5'd5:  c = mk(OP_ADD, SRC_C10, SRC_ZERO, DST_ACC);
				5'd6:  c = mk(OP_MUL, SRC_P, SRC_ACC, DST_ACC);
				5'd7:  c = mk(OP_ADD, SRC_C00, SRC_ZERO, DST_Q);
				5'd8:  c = mk(OP_MUL, SRC_T, SRC_C01, DST_ACC);
				5'd9:  c = mk(OP_ADD, SRC_Q, SRC_ZERO, DST_Q);
				5'd10: c = mk(OP_MUL, SRC_T, SRC_P, DST_ACC);
				5'd11: c = mk(OP_ADD, SRC_ZERO, SRC_ZERO, DST_TP);
				5'd12: c = mk(OP_MUL, SRC_P, SRC_C21, DST_ACC);
				5'd13: c = mk(OP_ADD, SRC_C11, SRC_ZERO, DST_ACC);
				5'd14: c = mk(OP_MUL, SRC_TP, SRC_ACC, DST_ACC);
				5'd15: c = mk(OP_ADD, SRC_Q, SRC_ZERO, DST_ACC);
				5'd16: c = mk(OP_MUL, SRC_C100, SRC_ACC, DST_ACC);
				default: c = mk(OP_END, SRC_ZERO, SRC_ZERO, DST_ACC);
			endcase
		end
		bsc_prog = c;
	endfunction

endpackage

// ===== rtl/core/bsc_div.sv =====
// Restoring divider, one quotient bit per cycle, for raw-sample scaling.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_div import bsc_pkg::*; #(
	parameter int FRAC_BITS = BSC_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               neg,
	input  logic [23:0]        dividend_mag,
	input  logic [23:0]        divisor,
	output logic               done,
	output logic signed [63:0] quot
);
	localparam int DW = 24 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dq_q;
	logic [24:0]   rem_q;
	logic [23:0]   dvs_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [24:0]   rem_sh;
	logic          ge;
	logic [63:0]   qm;
	logic [63:0]   qs;

	// one restoring step
	assign rem_sh = {rem_q[23:0], dq_q[DW-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {dividend_mag, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			dvs_q <= (divisor == 24'd0) ? 24'd1 : divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DW-2:0], ge};
			rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		end
	end

	// saturate to the 63-bit magnitude range, then apply sign
	assign qm   = 64'(dq_q);
	assign qs   = qm[63] ? 64'(FX_MAX) : qm;
	assign quot = neg_q ? -$signed(qs) : $signed(qs);
	assign done = done_q;

endmodule

// ===== rtl/core/bsc_mul.sv =====
// Fixed-point multiplier: 64x64 magnitude product from four 32x32 partial products,
// truncated by FRAC_BITS and saturated. Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_mul import bsc_pkg::*; #(
	parameter int FRAC_BITS = BSC_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic               done,
	output logic signed [63:0] prod
);
	logic [63:0]  ma_q;
	logic [63:0]  mb_q;
	logic         neg_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;
	logic [31:0]  pa;
	logic [31:0]  pb;
	logic [127:0] pp_sh;
	logic [127:0] shr;
	logic [63:0]  m;

	// partial product select: ll, lh, hl, hh
	assign pa    = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign pb    = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp_sh = {64'd0, pp_s1} << {sh_s1, 5'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= mag64(a);
			mb_q  <= mag64(b);
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_s1 <= pa * pb;
				sh_s1 <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + pp_sh;
		end
	end

	// drop fraction toward zero, saturate, apply sign
	assign shr  = acc_q >> FRAC_BITS;
	assign m    = (|shr[127:63]) ? 64'(FX_MAX) : shr[63:0];
	assign prod = neg_q ? -$signed(m) : $signed(m);
	assign done = done_q;

endmodule

// ===== rtl/core/bsc_dp.sv =====
// Datapath: configuration registers, coefficient unpacking, working registers,
// divider, multiplier, saturating adder and output register. Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_dp import bsc_pkg::*; #(
	parameter int FRAC_BITS = BSC_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_t                 ctl,
	output stat_t                st,
	input  logic [23:0]          raw_in,
	input  logic                 kind_in,
	input  logic                 cfg_wr,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [47:0]          cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [31:0]          out_value,
	output logic                 out_kind
);
	logic [47:0] w0_q, w1_q, w2_q;
	logic [23:0] tsc_q, psc_q;
	logic [23:0] raw_q, last_q;
	logic        kind_q;
	logic signed [63:0] t_q, p_q, acc_q, q_q, tp_q, mr_q;
	dst_t        div_dst_q;
	logic        add_done_q;
	logic        ov_q;
	logic [31:0] ovalue_q;
	logic        okind_q;

	logic signed [63:0] opa, opb;
	logic [23:0]        dsrc;
	logic [23:0]        dmag;
	logic               div_done, mul_done;
	logic signed [63:0] div_q, mul_p;
	logic signed [64:0] sum;
	logic signed [63:0] sum_sat;
	logic [63:0]        om;
	logic [63:0]        ofl;
	logic [31:0]        conv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q  <= '0;
			w1_q  <= '0;
			w2_q  <= '0;
			tsc_q <= SCALE_RESET;
			psc_q <= SCALE_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_COEF_0_5:    w0_q  <= cfg_data;
				REG_COEF_6_11:   w1_q  <= cfg_data;
				REG_COEF_12_17:  w2_q  <= cfg_data;
				REG_TEMP_SCALE:  tsc_q <= cfg_data[23:0];
				REG_PRESS_SCALE: psc_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// operand select; coefficients enter as c << FRAC_BITS, but c0 enters as c0 << (FRAC_BITS-1), i.e. halved
	function automatic logic signed [63:0] sel(input src_t s);
		logic signed [63:0] v;
		unique case (s)
			SRC_T:    v = t_q;
			SRC_P:    v = p_q;
			SRC_ACC:  v = acc_q;
			SRC_Q:    v = q_q;
			SRC_TP:   v = tp_q;
			SRC_C0H:  v = 64'($signed(w0_q[47:36])) <<< (FRAC_BITS - 1);
			SRC_C1:   v = 64'($signed(w0_q[35:24])) <<< FRAC_BITS;
			SRC_C00:  v = 64'($signed(w0_q[23:4])) <<< FRAC_BITS;
			SRC_C10:  v = 64'($signed({w0_q[3:0], w1_q[47:32]})) <<< FRAC_BITS;
			SRC_C01:  v = 64'($signed(w1_q[31:16])) <<< FRAC_BITS;
			SRC_C11:  v = 64'($signed(w1_q[15:0])) <<< FRAC_BITS;
			SRC_C20:  v = 64'($signed(w2_q[47:32])) <<< FRAC_BITS;
			SRC_C21:  v = 64'($signed(w2_q[31:16])) <<< FRAC_BITS;
			SRC_C30:  v = 64'($signed(w2_q[15:0])) <<< FRAC_BITS;
			SRC_C100: v = 64'sd100 <<< FRAC_BITS;
			default:  v = '0;
		endcase
		sel = v;
	endfunction

	assign opa = sel(ctl.cmd.a);
	assign opb = sel(ctl.cmd.b);

	// divider operands
	assign dsrc = (ctl.cmd.a == SRC_LAST) ? last_q : raw_q;
	assign dmag = dsrc[23] ? 24'(-dsrc) : dsrc;

	bsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (ctl.cmd.op == OP_DIV),
		.neg          (dsrc[23]),
		.dividend_mag (dmag),
		.divisor      ((ctl.cmd.dst == DST_T) ? tsc_q : psc_q),
		.done         (div_done),
		.quot         (div_q)
	);

	bsc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.cmd.op == OP_MUL),
		.a      (opa),
		.b      (opb),
		.done   (mul_done),
		.prod   (mul_p)
	);

	// saturating add of operand a and the last product
	assign sum = 65'(opa) + 65'(mr_q);
	always_comb begin
		if (sum > 65'(FX_MAX))
			sum_sat = FX_MAX;
		else if (sum < -65'(FX_MAX))
			sum_sat = -FX_MAX;
		else
			sum_sat = sum[63:0];
	end

	// sample latch and stored raw temperature
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_q <= '0;
		else if (ctl.accept && kind_in == KIND_TEMP)
			last_q <= raw_in;
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			raw_q  <= raw_in;
			kind_q <= kind_in;
		end
		if (ctl.cmd.op == OP_DIV)
			div_dst_q <= ctl.cmd.dst;
		if (div_done) begin
			if (div_dst_q == DST_T)
				t_q <= div_q;
			else
				p_q <= div_q;
		end
		if (mul_done)
			mr_q <= mul_p;
		if (ctl.cmd.op == OP_ADD) begin
			case (ctl.cmd.dst)
				DST_Q:   q_q   <= sum_sat;
				DST_TP:  tp_q  <= sum_sat;
				default: acc_q <= sum_sat;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			add_done_q <= 1'b0;
		else
			add_done_q <= (ctl.cmd.op == OP_ADD);
	end

	// final conversion: drop fraction toward zero, clamp to 32 bits
	assign om  = mag64(mr_q);
	assign ofl = om >> FRAC_BITS;
	always_comb begin
		if (mr_q[63])
			conv = (ofl > 64'h8000_0000) ? 32'h8000_0000 : 32'(-ofl);
		else
			conv = (ofl > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : ofl[31:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (ctl.out_load)
			ov_q <= 1'b1;
		else if (out_ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			ovalue_q <= conv;
			okind_q  <= kind_q;
		end
	end

	assign st.done     = div_done | mul_done | add_done_q;
	assign st.out_free = !ov_q || out_ready;
	assign out_valid   = ov_q;
	assign out_value   = ovalue_q;
	assign out_kind    = okind_q;

endmodule

// ===== rtl/core/bsc_ctrl.sv =====
// Controller: walks the step program for the accepted sample and issues commands
// to the datapath. Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_ctrl import bsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_kind,
	output logic  in_ready,
	input  stat_t st,
	output ctl_t  ctl
);
	state_t              state_q, state_nx;
	logic [STEP_W-1:0]   step_q;
	logic                kind_q;
	cmd_t                cmd;

	assign cmd = bsc_prog(kind_q, step_q);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_ISSUE;
			ST_ISSUE: state_nx = (cmd.op == OP_END) ? ST_OUT : ST_WAIT;
			ST_WAIT:  if (st.done) state_nx = ST_ISSUE;
			ST_OUT:   if (st.out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		ctl.accept   = (state_q == ST_IDLE) && in_valid;
		ctl.cmd      = cmd;
		ctl.out_load = (state_q == ST_OUT) && st.out_free;
		if (!(state_q == ST_ISSUE && cmd.op != OP_END))
			ctl.cmd.op = OP_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			kind_q  <= KIND_TEMP;
		end else begin
			state_q <= state_nx;
			if (ctl.accept) begin
				step_q <= '0;
				kind_q <= in_kind;
			end else if (state_q == ST_WAIT && st.done) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/baro_sensor_compensation_top.sv =====
// Barometric pressure / temperature compensation, top level.
// Uses bsc_pkg, bsc_ctrl, bsc_dp (with bsc_div, bsc_mul).
//
// Channels: s_* takes one sample (tuser = kind, 0 temperature / 1 pressure;
// tdata = 24-bit signed raw reading). m_* gives one result per sample
// (tuser = kind, tdata = compensated value x100, signed 32 bits, saturated).
// cfg_* writes a register: 0..2 calibration words, 3 temperature scale,
// 4 pressure scale; cfg_ready is always high. Write only while idle.
// Each step is issued in ST_ISSUE, then ST_WAIT waits for its unit's done.
// Temperature is one division, two multiplies and one add; pressure is
// two divisions, eight multiplies and seven adds. A sample is taken only
// in ST_IDLE, so the next one waits until the previous one has run all
// its steps; the bit-serial divider takes most of that time.
// A finished result sits in the output register; the next sample is taken
// while it waits, and is held at its end until the register is free.
// Reset clears the stored temperature, coefficients and control state and
// sets both scales to 524288.
`timescale 1ns / 1ps
module baro_sensor_compensation_top import bsc_pkg::*; #(
	parameter int FRAC_BITS = BSC_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // [23:0] raw_sample
	input  logic                 s_tuser,   // [0] req_type
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // [31:0] comp_value
	output logic                 m_tuser,   // [0] result_kind
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [47:0]          cfg_data
);
	ctl_t  ctl;
	stat_t st;

	assign cfg_ready = 1'b1;

	bsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.st       (st),
		.ctl      (ctl)
	);

	bsc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.raw_in    (s_tdata),
		.kind_in   (s_tuser),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (m_tdata),
		.out_kind  (m_tuser)
	);

endmodule

// ===== rtl/core/bsc_checker.sv =====
// Port-level checker for the compensation block, bound to the top level.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_checker import bsc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	logic       in_xfer, out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// samples accepted but results not yet transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (in_xfer && !out_xfer)
			pend_q <= pend_q + 1'b1;
		else if (out_xfer && !in_xfer)
			pend_q <= pend_q - 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("sample accepted while previous still in work");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 2'd0)
		else $error("result without an accepted sample");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two samples outstanding");

endmodule

bind baro_sensor_compensation_top bsc_checker u_bsc_checker (.*);
